### rtl/lef_pkg.sv
`timescale 1ns / 1ps

package lef_pkg;

  // Frame geometry limits and the widths that follow from them.
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);

  // Configuration register port.
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = CFG_W'(640);
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = CFG_W'(480);
  localparam logic [CFG_W-1:0] DIM_MIN          = CFG_W'(3);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1
  } cfg_reg_e;

  // Pixel and filter arithmetic.
  localparam int PIX_W = 8;
  localparam int SUM_W = PIX_W + 3;
  localparam logic [PIX_W-1:0] PIX_SAT = '1;

  // Queue between the front and the back.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // One queue entry describes all results caused by one input pixel.
  typedef struct packed {
    logic [ROW_W-1:0] row;     // row of the first result (one above the input)
    logic [COL_W-1:0] col;
    logic [PIX_W-1:0] value;   // filtered or passed value of the first result
    logic             second;  // last row: a border result for the input follows
    logic [PIX_W-1:0] pix;     // input pixel, used by the second result
  } rslt_entry_t;

  typedef struct packed {
    logic        valid;
    rslt_entry_t data;
  } q_push_t;

  typedef struct packed {
    logic               head_valid;
    logic [Q_CNT_W-1:0] count;
  } q_stat_t;

  // Clamp a dimension register into 3..maxv and return the last index.
  function automatic logic [CFG_W-1:0] dim_last(input logic [CFG_W-1:0] v,
                                                input logic [CFG_W-1:0] maxv);
    logic [CFG_W-1:0] e;
    e = v;
    if (v < DIM_MIN) begin
      e = DIM_MIN;
    end else if (v > maxv) begin
      e = maxv;
    end
    e = e - CFG_W'(1);
    return e;
  endfunction

endpackage

### rtl/laplacian_edge_filter_3x3_core.sv
`timescale 1ns / 1ps

// 3x3 four-neighbor Laplacian edge filter on a raster stream of 8-bit gray
// pixels. The core takes one pixel per clock unless in_stall_o holds it and
// reports, for pixel (r, c), |4*center - north - south - west - east|
// saturated to 255, or the pixel itself on the first and last row and
// column. The result for (r, c) leaves once pixel (r+1, c) has been taken,
// so row 0 yields nothing and every pixel of the last row yields two
// results (the one above, then its own); every result carries its row and
// column, and last_of_run_o marks the final result of each input pixel.
// Sustained input rate is one pixel per clock while the queue has room, set
// by the single read/write pass over the two line stores per pixel; on the
// last row the output port, one result per transfer, holds the input back,
// since each pixel there yields two results. A pixel's first result passes
// the line store read at the transfer, the filter into the queue and the
// output register before it is presented, with a four-entry queue between
// filter and output so short output stalls do not stop the input. Line
// stores need no clearing pass after reset. Write frame_width (index 0) and
// frame_height (index 1) only while the core is idle; any such write
// restarts the frame at row 0, column 0; values are clamped to 3..2048.
module laplacian_edge_filter_3x3_core import lef_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  // pixel input channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [PIX_W-1:0]     pixel_i,
  // result output channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [ROW_W-1:0]     out_row_o,
  output logic [COL_W-1:0]     out_col_o,
  output logic [PIX_W-1:0]     edge_value_o,
  output logic                 last_of_run_o
);

  q_push_t     push;
  q_stat_t     q_stat;
  rslt_entry_t head;
  logic        pop;

  // Registers are plain flops; accept every write transfer.
  assign cfg_ready_o = 1'b1;

  // Front: count position, run the line stores and the filter.
  lef_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .pixel_i     (pixel_i),
    .q_stat_i    (q_stat),
    .push_o      (push)
  );

  // Hold finished runs of results until the output side takes them.
  lef_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (q_stat)
  );

  // Back: split each run into one or two output transfers.
  lef_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .q_stat_i      (q_stat),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_row_o     (out_row_o),
    .out_col_o     (out_col_o),
    .edge_value_o  (edge_value_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

### rtl/lef_queue.sv
`timescale 1ns / 1ps

module lef_queue import lef_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  q_push_t     push_i,
  input  logic        pop_i,
  output rslt_entry_t head_o,
  output q_stat_t     stat_o
);

  rslt_entry_t        mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [Q_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [Q_CNT_W-1:0] count_q, count_d;
  logic               do_pop;

  assign do_pop = pop_i && (count_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i.valid) begin
      wr_ptr_d = wr_ptr_q + Q_PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + Q_PTR_W'(1);
    end
    if (push_i.valid && !do_pop) begin
      count_d = count_q + Q_CNT_W'(1);
    end else if (!push_i.valid && do_pop) begin
      count_d = count_q - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_ptr_q] <= push_i.data;
    end
  end

  assign head_o            = mem_q[rd_ptr_q];
  assign stat_o.head_valid = (count_q != '0);
  assign stat_o.count      = count_q;

endmodule

### rtl/lef_front.sv
`timescale 1ns / 1ps

module lef_front import lef_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [PIX_W-1:0]     pixel_i,
  input  q_stat_t              q_stat_i,
  output q_push_t              push_o
);

  logic [COL_W-1:0] width_last_q;
  logic [ROW_W-1:0] height_last_q;
  logic [COL_W-1:0] col_q;
  logic [ROW_W-1:0] row_q;
  logic             accept;
  logic             restart;

  // Line stores: rows r-2 and r-1.
  logic [PIX_W-1:0] older_mem [MAX_WIDTH];
  logic [PIX_W-1:0] newer_mem [MAX_WIDTH];

  // Work stage: read data and the item being finished.
  logic             b_valid_q;
  logic [PIX_W-1:0] b_pix_q;
  logic [ROW_W-1:0] b_row_q;
  logic [COL_W-1:0] b_col_q;
  logic             b_emit_q;
  logic             b_lastrow_q;
  logic             b_interior_q;
  logic [PIX_W-1:0] top_q;
  logic [PIX_W-1:0] mid_q;
  logic [PIX_W-1:0] right_q;
  logic [PIX_W-1:0] left_q;

  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] mag;
  logic [PIX_W-1:0] lap;

  // Reserve room for the item in the work stage as well.
  assign in_stall_o = (q_stat_i.count > Q_CNT_W'(Q_DEPTH - 2));
  assign accept     = in_valid_i && !in_stall_o;
  assign restart    = cfg_we_i &&
                      ((cfg_index_i == REG_FRAME_WIDTH) || (cfg_index_i == REG_FRAME_HEIGHT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_last_q  <= COL_W'(dim_last(FRAME_WIDTH_RST, CFG_W'(MAX_WIDTH)));
      height_last_q <= ROW_W'(dim_last(FRAME_HEIGHT_RST, CFG_W'(MAX_HEIGHT)));
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_FRAME_WIDTH: begin
          width_last_q <= COL_W'(dim_last(cfg_data_i, CFG_W'(MAX_WIDTH)));
        end
        REG_FRAME_HEIGHT: begin
          height_last_q <= ROW_W'(dim_last(cfg_data_i, CFG_W'(MAX_HEIGHT)));
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (restart) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      if (col_q == width_last_q) begin
        col_q <= '0;
        row_q <= (row_q == height_last_q) ? '0 : row_q + ROW_W'(1);
      end else begin
        col_q <= col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      left_q    <= '0;
    end else begin
      b_valid_q <= accept;
      if (b_valid_q) begin
        left_q <= mid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_pix_q      <= pixel_i;
      b_row_q      <= row_q;
      b_col_q      <= col_q;
      b_emit_q     <= (row_q != '0);
      b_lastrow_q  <= (row_q == height_last_q);
      b_interior_q <= (row_q >= ROW_W'(2)) && (col_q != '0) && (col_q != width_last_q);
      top_q        <= older_mem[col_q];
      mid_q        <= newer_mem[col_q];
      right_q      <= newer_mem[col_q + COL_W'(1)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_valid_q) begin
      older_mem[b_col_q] <= mid_q;
      newer_mem[b_col_q] <= b_pix_q;
    end
  end

  always_comb begin
    sum = {1'b0, mid_q, 2'b00} - SUM_W'(top_q) - SUM_W'(b_pix_q)
          - SUM_W'(left_q) - SUM_W'(right_q);
    mag = sum[SUM_W-1] ? (~sum + SUM_W'(1)) : sum;
    lap = (mag[SUM_W-1:PIX_W] != '0) ? PIX_SAT : mag[PIX_W-1:0];
  end

  always_comb begin
    push_o.valid       = b_valid_q && b_emit_q;
    push_o.data.row    = b_row_q - ROW_W'(1);
    push_o.data.col    = b_col_q;
    push_o.data.value  = b_interior_q ? lap : mid_q;
    push_o.data.second = b_lastrow_q;
    push_o.data.pix    = b_pix_q;
  end

endmodule

### rtl/lef_back.sv
`timescale 1ns / 1ps

module lef_back import lef_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rslt_entry_t      head_i,
  input  q_stat_t          q_stat_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [ROW_W-1:0] out_row_o,
  output logic [COL_W-1:0] out_col_o,
  output logic [PIX_W-1:0] edge_value_o,
  output logic             last_of_run_o
);

  logic             out_valid_q;
  logic             phase_q, phase_d;
  logic             load;
  logic [ROW_W-1:0] row_d;
  logic [PIX_W-1:0] value_d;
  logic             last_d;
  logic [ROW_W-1:0] row_q;
  logic [COL_W-1:0] col_q;
  logic [PIX_W-1:0] value_q;
  logic             last_q;

  assign load = !out_valid_q || !out_stall_i;

  always_comb begin
    phase_d = phase_q;
    pop_o   = 1'b0;
    row_d   = head_i.row;
    value_d = head_i.value;
    last_d  = !head_i.second;
    if (phase_q) begin
      row_d   = head_i.row + ROW_W'(1);
      value_d = head_i.pix;
      last_d  = 1'b1;
    end
    if (load && q_stat_i.head_valid) begin
      if (phase_q || !head_i.second) begin
        pop_o   = 1'b1;
        phase_d = 1'b0;
      end else begin
        phase_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      phase_q     <= 1'b0;
    end else begin
      phase_q <= phase_d;
      if (load) begin
        out_valid_q <= q_stat_i.head_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && q_stat_i.head_valid) begin
      row_q   <= row_d;
      col_q   <= head_i.col;
      value_q <= value_d;
      last_q  <= last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_row_o     = row_q;
  assign out_col_o     = col_q;
  assign edge_value_o  = value_q;
  assign last_of_run_o = last_q;

endmodule
